// ===== sv/gwnc_pkg.sv =====
package gwnc_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_MAX_RADIUS = 7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_HIGH  = 3'd5;

  localparam logic [6:0] RST_GRID_WIDTH  = 7'd64;
  localparam logic [6:0] RST_GRID_HEIGHT = 7'd64;
  localparam logic [2:0] RST_RADIUS_MIN  = 3'd1;
  localparam logic [2:0] RST_RADIUS_MAX  = 3'd1;
  localparam logic [7:0] RST_COUNT_LOW   = 8'd1;
  localparam logic [7:0] RST_COUNT_HIGH  = 8'd8;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam int CELL_W        = 2;
  localparam int FLAG_HOME     = 0;
  localparam int FLAG_NEIGHBOR = 1;

  localparam int COORD_W = 8;
  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

// ===== sv/gwnc_ram.sv =====
module gwnc_ram #(
  parameter int WIDTH  = 2,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/grid_window_neighbor_count_core.sv =====
// Neighbour counter over a grid of two-flag cells.
// The input stream carries load and query transactions: in_tuser is the
// action (0 load, 1 query); in_tdata holds the cell coordinates and, for
// a load, the home and neighbour flags. A load writes one cell of the flag
// memory in the cycle it is accepted and produces no result. A query reads
// the home cell and then walks the square window of radius radius_max,
// capped at MAX_RADIUS, one memory read per cycle, counting cells with
// the neighbour flag set and skipping cells off the grid and inside the
// inner radius; the single read port of the flag memory sets this pace. A
// query on a cell off the grid skips the walk and goes straight to its
// result. Only one query is worked on at a time, and loads are taken only
// while no query is in progress. The result sits in an output register
// until the receiver takes it; while it waits, further transactions
// are accepted and a following query stalls only once its own result
// is ready. Reset empties the output register and restores the register
// defaults; the flag memory is not cleared and every cell must be loaded
// before a query reads it. The user must write configuration (cfg_we,
// cfg_index, cfg_wdata) only while idle, which the block does not enforce.
module grid_window_neighbor_count_core #(
  parameter int MAX_WIDTH  = gwnc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gwnc_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = gwnc_pkg::DEF_MAX_RADIUS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,  // cell_x, cell_y, home_ok, neighbor_ok
  input  logic [0:0]                     in_tuser,  // action
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata, // match_count, qualifies
  input  logic                           cfg_we,
  input  logic [gwnc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gwnc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HOME,
    ST_SCAN,
    ST_FLUSH,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0] grid_width_r, grid_height_r;
  logic [2:0] radius_min_r, radius_max_r;
  logic [7:0] count_low_r, count_high_r;

  gwnc_pkg::coord_t hx_r, hy_r, nx_r, ny_r, x_lo_r, x_hi_r, y_hi_r;
  gwnc_pkg::coord_t hx_nxt, hy_nxt, nx_nxt, ny_nxt, x_lo_nxt, x_hi_nxt, y_hi_nxt;
  logic             rd_home_r, rd_home_nxt, rd_take_r, rd_take_nxt;
  logic             home_r, home_nxt;
  logic [7:0]       count_r, count_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [15:0]      out_tdata_r, out_tdata_nxt;

  logic [5:0]  in_cell_x, in_cell_y;
  logic        in_home_ok, in_neighbor_ok;
  logic        in_accept;
  logic [6:0]  w_eff, h_eff;
  logic [2:0]  r_eff;
  gwnc_pkg::coord_t in_x_c, in_y_c, r_c, rmin_c, w_c, h_c, dx, dy, dx_abs, dy_abs;
  logic        in_grid, skip;
  logic [6:0]  ux, uy;
  logic        ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [gwnc_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

  assign in_cell_x      = in_tdata[5:0];
  assign in_cell_y      = in_tdata[11:6];
  assign in_home_ok     = in_tdata[12];
  assign in_neighbor_ok = in_tdata[13];

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  assign w_eff = (32'(grid_width_r) > MAX_WIDTH) ? 7'(MAX_WIDTH) : grid_width_r;
  assign h_eff = (32'(grid_height_r) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : grid_height_r;
  assign r_eff = (32'(radius_max_r) > MAX_RADIUS) ? 3'(MAX_RADIUS) : radius_max_r;

  assign in_x_c = gwnc_pkg::coord_t'({2'b00, in_cell_x});
  assign in_y_c = gwnc_pkg::coord_t'({2'b00, in_cell_y});
  assign r_c    = gwnc_pkg::coord_t'({5'b00000, r_eff});
  assign rmin_c = gwnc_pkg::coord_t'({5'b00000, radius_min_r});
  assign w_c    = gwnc_pkg::coord_t'({1'b0, w_eff});
  assign h_c    = gwnc_pkg::coord_t'({1'b0, h_eff});

  assign dx      = nx_r - hx_r;
  assign dy      = ny_r - hy_r;
  assign dx_abs  = dx[gwnc_pkg::COORD_W-1] ? -dx : dx;
  assign dy_abs  = dy[gwnc_pkg::COORD_W-1] ? -dy : dy;
  assign in_grid = (nx_r >= 0) && (nx_r < w_c) && (ny_r >= 0) && (ny_r < h_c);
  assign skip    = (dx_abs < rmin_c) && (dy_abs < rmin_c);

  assign ux        = nx_r[gwnc_pkg::COORD_W-2:0];
  assign uy        = ny_r[gwnc_pkg::COORD_W-2:0];
  assign ram_raddr = ADDR_W'(uy) * ADDR_W'(MAX_WIDTH) + ADDR_W'(ux);
  assign ram_waddr = ADDR_W'(in_cell_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_cell_x);
  assign ram_wdata = {in_neighbor_ok, in_home_ok};
  assign ram_we    = in_accept && (in_tuser[0] == gwnc_pkg::ACT_LOAD) &&
                     (32'(in_cell_x) < MAX_WIDTH) && (32'(in_cell_y) < MAX_HEIGHT);

  gwnc_ram #(
    .WIDTH (gwnc_pkg::CELL_W),
    .DEPTH (DEPTH)
  ) u_flags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    hx_nxt         = hx_r;
    hy_nxt         = hy_r;
    nx_nxt         = nx_r;
    ny_nxt         = ny_r;
    x_lo_nxt       = x_lo_r;
    x_hi_nxt       = x_hi_r;
    y_hi_nxt       = y_hi_r;
    rd_home_nxt    = 1'b0;
    rd_take_nxt    = 1'b0;
    home_nxt       = home_r;
    count_nxt      = count_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;

    if (rd_home_r) begin
      home_nxt = ram_rdata[gwnc_pkg::FLAG_HOME];
    end
    if (rd_take_r && ram_rdata[gwnc_pkg::FLAG_NEIGHBOR] && (count_r != 8'hFF)) begin
      count_nxt = count_r + 8'd1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_tuser[0] == gwnc_pkg::ACT_QUERY)) begin
          hx_nxt    = in_x_c;
          hy_nxt    = in_y_c;
          nx_nxt    = in_x_c;
          ny_nxt    = in_y_c;
          x_lo_nxt  = in_x_c - r_c;
          x_hi_nxt  = in_x_c + r_c;
          y_hi_nxt  = in_y_c + r_c;
          home_nxt  = 1'b0;
          count_nxt = 8'd0;
          if ((in_x_c >= w_c) || (in_y_c >= h_c)) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_HOME;
          end
        end
      end
      ST_HOME: begin
        rd_home_nxt = 1'b1;
        nx_nxt      = x_lo_r;
        ny_nxt      = hy_r - r_c;
        state_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        rd_take_nxt = in_grid && !skip;
        if (nx_r == x_hi_r) begin
          nx_nxt = x_lo_r;
          if (ny_r == y_hi_r) begin
            state_nxt = ST_FLUSH;
          end else begin
            ny_nxt = ny_r + gwnc_pkg::coord_t'(1);
          end
        end else begin
          nx_nxt = nx_r + gwnc_pkg::coord_t'(1);
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {7'd0,
                            home_r && (count_r >= count_low_r) && (count_r <= count_high_r),
                            count_r};
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_home_r    <= 1'b0;
      rd_take_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_home_r    <= rd_home_nxt;
      rd_take_r    <= rd_take_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    hx_r        <= hx_nxt;
    hy_r        <= hy_nxt;
    nx_r        <= nx_nxt;
    ny_r        <= ny_nxt;
    x_lo_r      <= x_lo_nxt;
    x_hi_r      <= x_hi_nxt;
    y_hi_r      <= y_hi_nxt;
    home_r      <= home_nxt;
    count_r     <= count_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= gwnc_pkg::RST_GRID_WIDTH;
      grid_height_r <= gwnc_pkg::RST_GRID_HEIGHT;
      radius_min_r  <= gwnc_pkg::RST_RADIUS_MIN;
      radius_max_r  <= gwnc_pkg::RST_RADIUS_MAX;
      count_low_r   <= gwnc_pkg::RST_COUNT_LOW;
      count_high_r  <= gwnc_pkg::RST_COUNT_HIGH;
    end else if (cfg_we) begin
      case (cfg_index)
        gwnc_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata[6:0];
        gwnc_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_wdata[6:0];
        gwnc_pkg::REG_RADIUS_MIN:  radius_min_r  <= cfg_wdata[2:0];
        gwnc_pkg::REG_RADIUS_MAX:  radius_max_r  <= cfg_wdata[2:0];
        gwnc_pkg::REG_COUNT_LOW:   count_low_r   <= cfg_wdata;
        gwnc_pkg::REG_COUNT_HIGH:  count_high_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
